/* hw/rtl/hbcd_pkg.sv */
// Shared types, byte codes and helpers for the HTTP body chunked deframer.
// No dependencies; used by hbcd_core and http_body_chunked_deframer.
`default_nettype none

package hbcd_pkg;

	// Framing bytes
	localparam logic [7:0] BYTE_CR    = 8'h0D;
	localparam logic [7:0] BYTE_LF    = 8'h0A;
	localparam logic [7:0] BYTE_COLON = 8'h3A;

	// Register indexes on the configuration channel
	localparam logic CFG_BODY_MODE      = 1'b0;
	localparam logic CFG_CONTENT_LENGTH = 1'b1;

	// Body modes
	localparam logic MODE_FIXED   = 1'b0;
	localparam logic MODE_CHUNKED = 1'b1;

	// Output tdata width: fields packed, padded to whole bytes
	localparam int OUT_FIELD_W = 8 + 1 + 32 + 3;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_MALFORMED = 3'd1,
		ERR_EXTRA     = 3'd2,
		ERR_EARLY_END = 3'd3,
		ERR_OVERFLOW  = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		PH_SIZE         = 4'd0,
		PH_SIZE_LF      = 4'd1,
		PH_DATA         = 4'd2,
		PH_DATA_CR      = 4'd3,
		PH_DATA_LF      = 4'd4,
		PH_TRL_LINE     = 4'd5,
		PH_TRL_VALUE    = 4'd6,
		PH_TRL_VALUE_LF = 4'd7,
		PH_TRL_END_LF   = 4'd8,
		PH_DONE         = 4'd9
	} phase_t;

	// One result word
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        body_done;
		logic [31:0] body_length;
		err_t        error_code;
	} res_t;

	// Hex digit decode: bit 4 flags a digit, bits 3:0 give its value
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/hbcd_core.sv */
// Deframer state and per-byte step: registers, parse state, byte count, error latch.
// Depends on hbcd_pkg.
`default_nettype none

module hbcd_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_wr,
	input  wire               cfg_index,
	input  wire [31:0]        cfg_data,
	input  wire               step_en,
	input  wire [7:0]         in_byte,
	input  wire               in_end,
	output hbcd_pkg::res_t    res
);

	logic                 body_mode_q;
	logic [31:0]          content_length_q;
	hbcd_pkg::phase_t     phase_q, phase_d;
	logic [31:0]          chunk_rem_q, chunk_rem_d;
	logic [31:0]          byte_count_q, byte_count_d;
	logic                 digits_open_q, digits_open_d;
	logic                 name_seen_q, name_seen_d;
	hbcd_pkg::err_t       err_q, err_d;
	logic                 pay_d;
	logic                 done_now;
	logic [4:0]           hex;

	assign hex = hbcd_pkg::hex_digit(in_byte);

	// Done before this word
	assign done_now = (err_q == hbcd_pkg::ERR_NONE) &&
		((body_mode_q == hbcd_pkg::MODE_FIXED) ? (byte_count_q == content_length_q)
		                                        : (phase_q == hbcd_pkg::PH_DONE));

	// Next state for one word
	always_comb begin
		phase_d       = phase_q;
		chunk_rem_d   = chunk_rem_q;
		byte_count_d  = byte_count_q;
		digits_open_d = digits_open_q;
		name_seen_d   = name_seen_q;
		err_d         = err_q;
		pay_d         = 1'b0;
		if (err_q == hbcd_pkg::ERR_NONE) begin
			if (in_end) begin
				if (!done_now) err_d = hbcd_pkg::ERR_EARLY_END;
			end else if (body_mode_q == hbcd_pkg::MODE_FIXED) begin
				if (byte_count_q < content_length_q) begin
					byte_count_d = byte_count_q + 32'd1;
					pay_d        = 1'b1;
				end else begin
					err_d = hbcd_pkg::ERR_EXTRA;
				end
			end else begin
				case (phase_q)
					hbcd_pkg::PH_SIZE: begin
						if (in_byte == hbcd_pkg::BYTE_CR) begin
							digits_open_d = 1'b0;
							phase_d       = hbcd_pkg::PH_SIZE_LF;
						end else if (digits_open_q && hex[4]) begin
							if (chunk_rem_q[31:28] != 4'd0) err_d = hbcd_pkg::ERR_OVERFLOW;
							else chunk_rem_d = {chunk_rem_q[27:0], hex[3:0]};
						end else begin
							digits_open_d = 1'b0;
						end
					end
					hbcd_pkg::PH_SIZE_LF: begin
						if (in_byte == hbcd_pkg::BYTE_LF) begin
							if (chunk_rem_q == 32'd0) begin
								phase_d     = hbcd_pkg::PH_TRL_LINE;
								name_seen_d = 1'b0;
							end else begin
								phase_d = hbcd_pkg::PH_DATA;
							end
						end else if (in_byte != hbcd_pkg::BYTE_CR) begin
							phase_d = hbcd_pkg::PH_SIZE;
						end
					end
					hbcd_pkg::PH_DATA: begin
						if (byte_count_q == 32'hFFFF_FFFF) begin
							err_d = hbcd_pkg::ERR_OVERFLOW;
						end else begin
							byte_count_d = byte_count_q + 32'd1;
							chunk_rem_d  = chunk_rem_q - 32'd1;
							pay_d        = 1'b1;
							if (chunk_rem_q == 32'd1) phase_d = hbcd_pkg::PH_DATA_CR;
						end
					end
					hbcd_pkg::PH_DATA_CR: begin
						if (in_byte == hbcd_pkg::BYTE_CR) phase_d = hbcd_pkg::PH_DATA_LF;
						else err_d = hbcd_pkg::ERR_MALFORMED;
					end
					hbcd_pkg::PH_DATA_LF: begin
						if (in_byte == hbcd_pkg::BYTE_LF) begin
							phase_d       = hbcd_pkg::PH_SIZE;
							chunk_rem_d   = 32'd0;
							digits_open_d = 1'b1;
						end else begin
							err_d = hbcd_pkg::ERR_MALFORMED;
						end
					end
					hbcd_pkg::PH_TRL_LINE: begin
						if (in_byte == hbcd_pkg::BYTE_CR) begin
							if (!name_seen_q) phase_d = hbcd_pkg::PH_TRL_END_LF;
							else err_d = hbcd_pkg::ERR_MALFORMED;
						end else if (in_byte == hbcd_pkg::BYTE_COLON) begin
							if (name_seen_q) phase_d = hbcd_pkg::PH_TRL_VALUE;
							else err_d = hbcd_pkg::ERR_MALFORMED;
						end else begin
							name_seen_d = 1'b1;
						end
					end
					hbcd_pkg::PH_TRL_VALUE: begin
						if (in_byte == hbcd_pkg::BYTE_CR) phase_d = hbcd_pkg::PH_TRL_VALUE_LF;
					end
					hbcd_pkg::PH_TRL_VALUE_LF: begin
						if (in_byte == hbcd_pkg::BYTE_LF) begin
							phase_d     = hbcd_pkg::PH_TRL_LINE;
							name_seen_d = 1'b0;
						end else begin
							err_d = hbcd_pkg::ERR_MALFORMED;
						end
					end
					hbcd_pkg::PH_TRL_END_LF: begin
						if (in_byte == hbcd_pkg::BYTE_LF) phase_d = hbcd_pkg::PH_DONE;
						else err_d = hbcd_pkg::ERR_MALFORMED;
					end
					default: begin
						err_d = hbcd_pkg::ERR_EXTRA;
					end
				endcase
			end
		end
	end

	// Result word from the updated state
	always_comb begin
		res.payload_valid = pay_d;
		res.payload_byte  = pay_d ? in_byte : 8'd0;
		res.body_length   = byte_count_d;
		res.error_code    = err_d;
		res.body_done     = (err_d == hbcd_pkg::ERR_NONE) &&
			((body_mode_q == hbcd_pkg::MODE_FIXED) ? (byte_count_d == content_length_q)
			                                        : (phase_d == hbcd_pkg::PH_DONE));
	end

	// Registers and parse state; a register write clears the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_mode_q      <= hbcd_pkg::MODE_FIXED;
			content_length_q <= 32'd0;
			phase_q          <= hbcd_pkg::PH_SIZE;
			chunk_rem_q      <= 32'd0;
			byte_count_q     <= 32'd0;
			digits_open_q    <= 1'b1;
			name_seen_q      <= 1'b0;
			err_q            <= hbcd_pkg::ERR_NONE;
		end else if (cfg_wr) begin
			if (cfg_index == hbcd_pkg::CFG_BODY_MODE) body_mode_q <= cfg_data[0];
			else content_length_q <= cfg_data;
			phase_q       <= hbcd_pkg::PH_SIZE;
			chunk_rem_q   <= 32'd0;
			byte_count_q  <= 32'd0;
			digits_open_q <= 1'b1;
			name_seen_q   <= 1'b0;
			err_q         <= hbcd_pkg::ERR_NONE;
		end else if (step_en) begin
			phase_q       <= phase_d;
			chunk_rem_q   <= chunk_rem_d;
			byte_count_q  <= byte_count_d;
			digits_open_q <= digits_open_d;
			name_seen_q   <= name_seen_d;
			err_q         <= err_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/http_body_chunked_deframer.sv */
// HTTP message body deframer (fixed length or chunked), one byte word per cycle while the result stream does not stall.
// An accepted word passes through the input register, then the result register, before its result is valid.
// Each word is handled by one combinational step in hbcd_core; m_axis_tready low stalls both registers.
// Reset (arst_n low, async): fixed mode, content_length 0, parse state and error cleared.
// A configuration write also clears the parse state. Depends on hbcd_pkg, hbcd_core.
`default_nettype none

module http_body_chunked_deframer (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration write channel
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire                              cfg_index,
	input  wire [31:0]                       cfg_data,
	// input stream
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [7:0]                        s_axis_tdata,  // [7:0] data_byte
	input  wire                              s_axis_tuser,  // [0] stream_end
	// result stream
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [hbcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// [7:0] payload_byte, [8] body_done, [40:9] body_length, [43:41] error_code, rest 0
	output logic                             m_axis_tuser   // [0] payload_valid
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            adv;
	logic            step_en;
	hbcd_pkg::res_t  res_s1;
	logic            out_valid_q;
	hbcd_pkg::res_t  out_q;

	assign cfg_ready     = 1'b1;
	assign adv           = !out_valid_q || m_axis_tready;
	assign step_en       = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	// Input register: load on accept, drain when the step fires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	hbcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step_en   (step_en),
		.in_byte   (byte_s1),
		.in_end    (end_s1),
		.res       (res_s1)
	);

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			out_q <= res_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.payload_valid;
	assign m_axis_tdata  = {{(hbcd_pkg::OUT_TDATA_W - hbcd_pkg::OUT_FIELD_W){1'b0}},
		out_q.error_code, out_q.body_length, out_q.body_done, out_q.payload_byte};

	// An error result never carries payload or done
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_q.error_code != hbcd_pkg::ERR_NONE)
			|-> !out_q.payload_valid && !out_q.body_done)
		else $error("error result carries payload or done");

	// A payload word always counts toward the body length
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_q.payload_valid |-> out_q.body_length != 32'd0)
		else $error("payload word with zero body length");

	// An empty input register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");

	// A stalled input register keeps its word
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1) && $stable(end_s1))
		else $error("input register lost a stalled word");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for http_body_chunked_deframer: fixed and chunked bodies.
// Predicts every result word in-line and compares it field by field with the block.
// Depends on hbcd_pkg and the http_body_chunked_deframer RTL.
`timescale 1ns / 1ps

module tb_top;
	import hbcd_pkg::*;

	localparam int RANDOM_ITEMS = 1150;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {RDY_FULL, RDY_RANDOM, RDY_BURSTY} rdy_style_t;

	// One directed step: a register write or a byte, with an optional typed-in result
	typedef struct packed {
		row_kind_t   kind;
		logic        reg_idx;
		logic [31:0] reg_val;
		logic [7:0]  data;
		logic        ending;
		logic        typed;
		res_t        want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = 1'b0;
	logic [31:0]            cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;

	http_body_chunked_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Predictor state: registers and parse state
	logic        cur_mode;
	logic [31:0] cur_length;
	phase_t      ph;
	logic [31:0] chunk_left;
	logic [31:0] body_count;
	logic        digits_open;
	logic        name_seen;
	err_t        err_held;

	res_t        predicted_results[$];
	logic [8:0]  script[$];          // {stream_end, data_byte}
	int          mismatch_count = 0;
	int          burst_left = 0;
	logic        steady = 1'b0;

	function automatic void clear_parse();
		ph          = PH_SIZE;
		chunk_left  = '0;
		body_count  = '0;
		digits_open = 1'b1;
		name_seen   = 1'b0;
		err_held    = ERR_NONE;
	endfunction

	function automatic logic body_complete();
		if (err_held != ERR_NONE) return 1'b0;
		if (cur_mode == MODE_FIXED) return body_count == cur_length;
		return ph == PH_DONE;
	endfunction

	// Advance the predictor by one input word and return the result word it causes
	function automatic res_t deframe_step(input logic [7:0] b, input logic ending);
		res_t       r;
		logic       pass;
		logic       is_dig;
		logic [3:0] nib;
		pass = 1'b0;
		if (err_held == ERR_NONE) begin
			if (ending) begin
				if (!body_complete()) err_held = ERR_EARLY_END;
			end else if (cur_mode == MODE_FIXED) begin
				if (body_count < cur_length) begin
					body_count = body_count + 1;
					pass = 1'b1;
				end else begin
					err_held = ERR_EXTRA;
				end
			end else begin
				case (ph)
					PH_SIZE: begin
						is_dig = 1'b1;
						nib = '0;
						if (b >= "0" && b <= "9") nib = 4'(b - 8'h30);
						else if (b >= "A" && b <= "F") nib = 4'(b - 8'h37);
						else if (b >= "a" && b <= "f") nib = 4'(b - 8'h57);
						else is_dig = 1'b0;
						if (b == BYTE_CR) begin
							digits_open = 1'b0;
							ph = PH_SIZE_LF;
						end else if (digits_open && is_dig) begin
							if (chunk_left > 32'h0FFF_FFFF) err_held = ERR_OVERFLOW;
							else chunk_left = {chunk_left[27:0], nib};
						end else begin
							digits_open = 1'b0;
						end
					end
					PH_SIZE_LF: begin
						if (b == BYTE_LF) begin
							if (chunk_left == 0) begin
								ph = PH_TRL_LINE;
								name_seen = 1'b0;
							end else begin
								ph = PH_DATA;
							end
						end else if (b != BYTE_CR) begin
							ph = PH_SIZE;
						end
					end
					PH_DATA: begin
						if (body_count == 32'hFFFF_FFFF) begin
							err_held = ERR_OVERFLOW;
						end else begin
							body_count = body_count + 1;
							chunk_left = chunk_left - 1;
							if (chunk_left == 0) ph = PH_DATA_CR;
							pass = 1'b1;
						end
					end
					PH_DATA_CR: begin
						if (b == BYTE_CR) ph = PH_DATA_LF;
						else err_held = ERR_MALFORMED;
					end
					PH_DATA_LF: begin
						if (b == BYTE_LF) begin
							ph = PH_SIZE;
							chunk_left = '0;
							digits_open = 1'b1;
						end else begin
							err_held = ERR_MALFORMED;
						end
					end
					PH_TRL_LINE: begin
						if (b == BYTE_CR) begin
							if (!name_seen) ph = PH_TRL_END_LF;
							else err_held = ERR_MALFORMED;
						end else if (b == BYTE_COLON) begin
							if (name_seen) ph = PH_TRL_VALUE;
							else err_held = ERR_MALFORMED;
						end else begin
							name_seen = 1'b1;
						end
					end
					PH_TRL_VALUE: begin
						if (b == BYTE_CR) ph = PH_TRL_VALUE_LF;
					end
					PH_TRL_VALUE_LF: begin
						if (b == BYTE_LF) begin
							ph = PH_TRL_LINE;
							name_seen = 1'b0;
						end else begin
							err_held = ERR_MALFORMED;
						end
					end
					PH_TRL_END_LF: begin
						if (b == BYTE_LF) ph = PH_DONE;
						else err_held = ERR_MALFORMED;
					end
					default: err_held = ERR_EXTRA;
				endcase
			end
		end
		r.payload_byte  = pass ? b : 8'h00;
		r.payload_valid = pass;
		r.body_done     = body_complete();
		r.body_length   = body_count;
		r.error_code    = err_held;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
	endtask

	// Write one register once every result is out, then mirror it in the predictor
	task automatic write_register(input logic idx, input logic [31:0] val);
		s_axis_tvalid = 1'b0;
		while (predicted_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BODY_MODE) cur_mode = val[0];
		else cur_length = val;
		clear_parse();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Send one word, in bursts with random gaps unless steady is set; predict it once accepted
	task automatic feed_byte(input logic [7:0] b, input logic ending, input logic typed,
			input res_t want);
		res_t guess;
		if (!steady) begin
			if (burst_left == 0) begin
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tuser  = ending;
		do @(posedge clk); while (!s_axis_tready);
		guess = deframe_step(b, ending);
		predicted_results.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	// Script building
	task automatic put_byte(input logic [7:0] b);
		script.push_back({1'b0, b});
	endtask

	task automatic put_end();
		script.push_back({1'b1, 8'($urandom)});
	endtask

	task automatic put_crlf();
		put_byte(BYTE_CR);
		put_byte(BYTE_LF);
	endtask

	task automatic put_hex(input logic [39:0] v, input int digits);
		logic [3:0] nib;
		for (int i = digits - 1; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 10) put_byte(8'h30 + 8'(nib));
			else put_byte(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10);
		end
	endtask

	function automatic logic [7:0] pick_except(input logic [7:0] a, input logic [7:0] c);
		logic [7:0] b;
		do b = 8'($urandom); while (b == a || b == c);
		return b;
	endfunction

	// Bytes that steer the parser more often than plain random ones
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 6))
			0: return BYTE_CR;
			1: return BYTE_LF;
			2: return BYTE_COLON;
			3: return "0";
			4: return "a";
			default: return 8'($urandom);
		endcase
	endfunction

	// Chunk extension, sometimes with a lone CR inside it
	task automatic put_ext();
		put_byte(";");
		repeat ($urandom_range(0, 4)) put_byte(pick_except(BYTE_CR, BYTE_CR));
		if ($urandom_range(0, 2) == 0) begin
			put_byte(BYTE_CR);
			put_byte(pick_except(BYTE_LF, BYTE_CR));
		end
	endtask

	// Well-formed chunked body: chunks, last chunk, trailer lines, empty line
	task automatic build_chunked();
		int size;
		for (int k = $urandom_range(0, 3); k > 0; k--) begin
			size = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
			put_hex(40'(size), ((size > 15) ? 2 : 1) + $urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0) put_ext();
			put_crlf();
			repeat (size) put_byte(8'($urandom));
			put_crlf();
		end
		case ($urandom_range(0, 2))
			0: put_hex(40'd0, $urandom_range(1, 3));
			1: ;
			default: put_byte(";");
		endcase
		if ($urandom_range(0, 2) == 0) put_ext();
		put_crlf();
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(1, 4)) put_byte(pick_except(BYTE_CR, BYTE_COLON));
			put_byte(BYTE_COLON);
			repeat ($urandom_range(0, 5)) put_byte(pick_except(BYTE_CR, BYTE_CR));
			put_crlf();
		end
		put_crlf();
	endtask

	// Directed steps
	row_t plan [0:22] = '{
		// fixed mode after reset: no body, close is harmless, any byte is extra
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd0, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd0, ERR_EXTRA}},
		// two-byte body, then close after done
		'{ROW_CFG, CFG_CONTENT_LENGTH, 32'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 32'd1, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 32'd2, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h5A, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd2, ERR_NONE}},
		// largest length, early close, error held
		'{ROW_CFG, CFG_CONTENT_LENGTH, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 32'd1, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h00, 1'b1, 1'b1,
			'{8'h00, 1'b0, 1'b0, 32'd1, ERR_EARLY_END}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, 8'h7F, 1'b0, 1'b1,
			'{8'h00, 1'b0, 1'b0, 32'd1, ERR_EARLY_END}},
		// chunked: "1;" CRLF "Z" CRLF, digitless last chunk, empty trailer, extra byte
		'{ROW_CFG, CFG_BODY_MODE, 32'(MODE_CHUNKED), 8'h00, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, "1", 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, ";", 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_CR, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_LF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, "Z", 1'b0, 1'b1, '{8'h5A, 1'b1, 1'b0, 32'd1, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_CR, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_LF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_CR, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_LF, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_CR, 1'b0, 1'b0, '0},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, BYTE_LF, 1'b0, 1'b1,
			'{8'h00, 1'b0, 1'b1, 32'd1, ERR_NONE}},
		'{ROW_ITEM, CFG_BODY_MODE, 32'd0, "x", 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd1, ERR_EXTRA}}
	};

	// Receiver: switch between full, random and bursty stall styles, each held for a random run
	rdy_style_t rdy_style = RDY_FULL;
	int         style_left = 0;
	int         stall_left = 0;

	always @(negedge clk) begin
		if (style_left == 0) begin
			rdy_style  = rdy_style_t'($urandom_range(0, 2));
			style_left = $urandom_range(20, 80);
		end
		style_left--;
		case (rdy_style)
			RDY_FULL:   m_axis_tready = 1'b1;
			RDY_RANDOM: m_axis_tready = ($urandom_range(0, 9) < 7);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					m_axis_tready = 1'b0;
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(1, 10);
					m_axis_tready = 1'b0;
				end else begin
					m_axis_tready = 1'b1;
				end
			end
		endcase
	end

	// Compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.payload_byte  = m_axis_tdata[7:0];
			seen.payload_valid = m_axis_tuser;
			seen.body_done     = m_axis_tdata[8];
			seen.body_length   = m_axis_tdata[40:9];
			seen.error_code    = err_t'(m_axis_tdata[43:41]);
			if (predicted_results.size() == 0) begin
				report_mismatch("word with nothing pending", seen.body_length, 32'd0);
			end else begin
				want = predicted_results.pop_front();
				if (seen.payload_byte !== want.payload_byte)
					report_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
				if (seen.payload_valid !== want.payload_valid)
					report_mismatch("payload_valid", seen.payload_valid, want.payload_valid);
				if (seen.body_done !== want.body_done)
					report_mismatch("body_done", seen.body_done, want.body_done);
				if (seen.body_length !== want.body_length)
					report_mismatch("body_length", seen.body_length, want.body_length);
				if (seen.error_code !== want.error_code)
					report_mismatch("error_code", seen.error_code, want.error_code);
			end
		end
	end

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int          random_sent;
		int          pick;
		int          n;
		int          k;
		int          digits;
		logic [31:0] len;
		logic [39:0] big;
		random_sent = 0;
		cur_mode    = MODE_FIXED;
		cur_length  = '0;
		clear_parse();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) write_register(plan[i].reg_idx, plan[i].reg_val);
			else feed_byte(plan[i].data, plan[i].ending, plan[i].typed, plan[i].want);
		end

		// Random sessions, each starting from a register write on an idle block
		while (random_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			script.delete();
			pick = $urandom_range(0, 99);
			if (pick < 28) begin
				// fixed length: exact, short, or with extra bytes
				write_register(CFG_BODY_MODE, 32'(MODE_FIXED));
				case ($urandom_range(0, 9))
					0: len = 32'd0;
					1: len = 32'hFFFF_FFFF;
					2: len = $urandom();
					default: len = $urandom_range(1, 24);
				endcase
				write_register(CFG_CONTENT_LENGTH, len);
				n = (len <= 24) ? int'(len) : $urandom_range(0, 6);
				case ($urandom_range(0, 3))
					0: n = n - $urandom_range(0, n);
					1: n = n + $urandom_range(1, 3);
					default: ;
				endcase
				repeat (n) put_byte(8'($urandom));
				if ($urandom_range(0, 1) == 0) put_end();
			end else if (pick < 83) begin
				// chunked body, sometimes damaged or cut short
				write_register(CFG_BODY_MODE, 32'(MODE_CHUNKED));
				if ($urandom_range(0, 4) == 0) write_register(CFG_CONTENT_LENGTH, $urandom());
				build_chunked();
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, script.size() - 1);
					if ($urandom_range(0, 1) == 0) begin
						script[k] = {1'b0, noise_byte()};
					end else begin
						while (script.size() > k) void'(script.pop_back());
						put_end();
					end
				end
				case ($urandom_range(0, 4))
					0: put_end();
					1: put_byte(noise_byte());
					2: begin
						put_end();
						put_end();
					end
					default: ;
				endcase
			end else if (pick < 91) begin
				// oversized chunk size lines, or the largest 8-digit size with a body cut short
				write_register(CFG_BODY_MODE, 32'(MODE_CHUNKED));
				if ($urandom_range(0, 1) == 0) begin
					digits = $urandom_range(9, 10);
					big = {8'($urandom), 32'($urandom)};
					big[digits*4-1 -: 4] = 4'($urandom_range(1, 15));
					put_hex(big, digits);
					put_crlf();
					repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
				end else begin
					put_hex(40'hFF_FFFF_FFFF, 8);
					put_crlf();
					repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
					put_end();
				end
			end else begin
				// noise in either mode
				write_register(CFG_BODY_MODE, 32'($urandom_range(0, 1)));
				write_register(CFG_CONTENT_LENGTH, $urandom_range(0, 8));
				repeat ($urandom_range(4, 30)) begin
					if ($urandom_range(0, 9) == 0) put_end();
					else put_byte(noise_byte());
				end
			end
			foreach (script[j]) begin
				feed_byte(script[j][7:0], script[j][8], 1'b0, '0);
				random_sent++;
			end
		end

		// Drain and finish
		s_axis_tvalid = 1'b0;
		while (predicted_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/hbcd_pkg.sv
hw/rtl/hbcd_core.sv
hw/rtl/http_body_chunked_deframer.sv
sim/tb_top.sv
